/* src/sea_pkg.sv */
// shared types, codes, defaults and elaboration helpers for the scalar alu
package sea_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int WEIGHT_WIDTH    = 32;
   localparam int OP_WIDTH        = 4;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 3;

   // Q16.16 one
   localparam logic signed [WEIGHT_WIDTH-1:0] WEIGHT_RESET = 32'sh0001_0000;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_SUM      = 4'd0,
      OP_SUB      = 4'd1,
      OP_PROD     = 4'd2,
      OP_DIV      = 4'd3,
      OP_FLOORDIV = 4'd4,
      OP_MIN      = 4'd5,
      OP_MAX      = 4'd6,
      OP_SQRDIFF  = 4'd7,
      OP_POW      = 4'd8,
      OP_EQUAL    = 4'd9,
      OP_NEG      = 4'd10,
      OP_ABS      = 4'd11
   } op_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK          = 2'd0,
      ST_DIV_ZERO    = 2'd1,
      ST_SATURATED   = 2'd2,
      ST_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_OP_SELECT     = 3'd0,
      CSR_WEIGHTS_ON    = 3'd1,
      CSR_WEIGHT_FIRST  = 3'd2,
      CSR_WEIGHT_SECOND = 3'd3,
      CSR_SCALAR_VALUE  = 3'd4,
      CSR_SCALAR_FIRST  = 3'd5
   } csr_index_type;

   // base to the power k, pinned just above cap once it passes it
   function automatic logic [127:0] sat_pow(input logic [127:0] base, input int k,
                                            input logic [127:0] cap);
      logic [127:0] acc;
      acc = 128'd1;
      for (int i = 0; i < k; i++) begin
         acc = acc * base;
         if (acc > cap) acc = cap + 128'd1;
      end
      return acc;
   endfunction

   // smallest magnitude whose k-th power reaches 2^(w-1)
   function automatic logic [63:0] pow_threshold(input int k, input int w);
      logic [127:0] lim;
      logic [127:0] lo;
      logic [127:0] hi;
      logic [127:0] mid;
      lim = 128'd1 << (w - 1);
      lo  = 128'd1;
      hi  = lim;
      while (lo < hi) begin
         mid = (lo + hi) >> 1;
         if (sat_pow(mid, k, lim) >= lim) hi = mid;
         else lo = mid + 128'd1;
      end
      return lo[63:0];
   endfunction

   // threshold to the k-th power lands exactly on 2^(w-1)
   function automatic logic pow_exact(input int k, input int w);
      logic [127:0] lim;
      lim = 128'd1 << (w - 1);
      return sat_pow({64'd0, pow_threshold(k, w)}, k, lim) == lim;
   endfunction

endpackage

/* src/sea_div.sv */
// pipelined signed divider, one quotient bit per stage, truncating toward zero
module sea_div
   import sea_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] num,
   input  logic signed [DATA_WIDTH-1:0] den,
   output logic signed [DATA_WIDTH-1:0] quo,
   output status_type                   status
);

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0] num_ff [0:W];
   logic [W-1:0] den_ff [0:W];
   logic [W-1:0] rem_ff [0:W];
   logic [W-1:0] quo_ff [0:W];
   logic         neg_ff [0:W];
   logic         dz_ff  [0:W];
   logic         ovf_ff [0:W];

   logic [W-1:0] num_mag_in;
   logic [W-1:0] den_mag_in;

   // magnitudes and special cases
   assign num_mag_in = num[W-1] ? W'(-num) : num;
   assign den_mag_in = den[W-1] ? W'(-den) : den;

   always_ff @(posedge clock) begin
      num_ff[0] <= num_mag_in;
      den_ff[0] <= den_mag_in;
      rem_ff[0] <= '0;
      quo_ff[0] <= '0;
      neg_ff[0] <= num[W-1] ^ den[W-1];
      dz_ff[0]  <= (den == '0);
      ovf_ff[0] <= (num == MIN_VAL) && (&den);
   end

   // restoring stages
   for (genvar k = 0; k < W; k++) begin : g_stage
      logic [W:0] trial;
      logic       fits;
      assign trial = {rem_ff[k], num_ff[k][W-1]};
      assign fits  = trial >= {1'b0, den_ff[k]};

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= fits ? W'(trial - {1'b0, den_ff[k]}) : trial[W-1:0];
         num_ff[k+1] <= {num_ff[k][W-2:0], 1'b0};
         quo_ff[k+1] <= {quo_ff[k][W-2:0], fits};
         den_ff[k+1] <= den_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         dz_ff[k+1]  <= dz_ff[k];
         ovf_ff[k+1] <= ovf_ff[k];
      end
   end

   // sign and special results
   always_comb begin
      if (dz_ff[W]) begin
         quo    = '0;
         status = ST_DIV_ZERO;
      end else if (ovf_ff[W]) begin
         quo    = MAX_VAL;
         status = ST_SATURATED;
      end else begin
         quo    = neg_ff[W] ? W'(-quo_ff[W]) : quo_ff[W];
         status = ST_OK;
      end
   end

endmodule

/* src/sea_pow.sv */
// pipelined saturating integer power by square and multiply
module sea_pow
   import sea_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic signed [DATA_WIDTH-1:0] base,
   input  logic signed [DATA_WIDTH-1:0] expo,
   output logic signed [DATA_WIDTH-1:0] res,
   output status_type                   status
);

   localparam int W        = DATA_WIDTH;
   localparam int EXP_BITS = $clog2(W);
   localparam int CNT_BITS = $clog2(W + 1);
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]   amag_in;
   logic [W-1:1]   ge_in;
   logic [W-1:1]   tie_in;
   logic           spec_in;
   logic [W-1:0]   sres_in;
   status_type     sst_in;

   logic [W-1:0]   s1_base_ff;
   logic [W-1:0]   s1_expo_ff;
   logic [W-1:1]   s1_ge_ff;
   logic [W-1:1]   s1_tie_ff;
   logic           s1_spec_ff;
   logic [W-1:0]   s1_res_ff;
   status_type     s1_st_ff;

   logic [CNT_BITS-1:0] first_k;
   logic                first_tie;
   logic [CNT_BITS-1:0] ovk;
   logic                over;

   logic [W-1:0]        acc_ff   [0:EXP_BITS];
   logic [W-1:0]        pbase_ff [0:EXP_BITS];
   logic [EXP_BITS-1:0] ebits_ff [0:EXP_BITS];
   logic                spec_ff  [0:EXP_BITS];
   logic [W-1:0]        sres_ff  [0:EXP_BITS];
   status_type          sst_ff   [0:EXP_BITS];

   assign amag_in = base[W-1] ? W'(-base) : base;

   // compare magnitude against each k-th root threshold
   for (genvar k = 1; k < W; k++) begin : g_thresh
      localparam logic [W-1:0] THRESH = W'(pow_threshold(k, W));
      localparam logic TIE_OK = pow_exact(k, W) && (k % 2 == 1);
      assign ge_in[k]  = amag_in >= THRESH;
      assign tie_in[k] = TIE_OK && (amag_in == THRESH);
   end

   // trivial bases and exponents
   always_comb begin
      spec_in = 1'b1;
      sres_in = '0;
      sst_in  = ST_OK;
      if (expo[W-1]) begin
         if (base == '0) begin
            sst_in = ST_DIV_ZERO;
         end else if (base == W'(1)) begin
            sres_in = W'(1);
         end else if (&base) begin
            sres_in = expo[0] ? '1 : W'(1);
         end
      end else if (expo == '0) begin
         sres_in = W'(1);
      end else if (base == '0) begin
         sres_in = '0;
      end else if (base == W'(1)) begin
         sres_in = W'(1);
      end else if (&base) begin
         sres_in = expo[0] ? '1 : W'(1);
      end else begin
         spec_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      s1_base_ff <= base;
      s1_expo_ff <= expo;
      s1_ge_ff   <= ge_in;
      s1_tie_ff  <= tie_in;
      s1_spec_ff <= spec_in;
      s1_res_ff  <= sres_in;
      s1_st_ff   <= sst_in;
   end

   // first power that leaves the range
   always_comb begin
      first_k   = CNT_BITS'(1);
      first_tie = 1'b0;
      for (int k = W - 1; k >= 1; k--) begin
         if (s1_ge_ff[k]) begin
            first_k   = CNT_BITS'(k);
            first_tie = s1_tie_ff[k];
         end
      end
   end

   assign ovk  = first_k + CNT_BITS'(s1_base_ff[W-1] & first_tie);
   assign over = !s1_expo_ff[W-1] && (s1_expo_ff >= W'(ovk));

   always_ff @(posedge clock) begin
      acc_ff[0]   <= W'(1);
      pbase_ff[0] <= s1_base_ff;
      ebits_ff[0] <= s1_expo_ff[EXP_BITS-1:0];
      spec_ff[0]  <= s1_spec_ff || over;
      if (s1_spec_ff) begin
         sres_ff[0] <= s1_res_ff;
         sst_ff[0]  <= s1_st_ff;
      end else begin
         sres_ff[0] <= (s1_base_ff[W-1] && ovk[0]) ? MIN_VAL : MAX_VAL;
         sst_ff[0]  <= ST_SATURATED;
      end
   end

   // one exponent bit per stage
   for (genvar j = 0; j < EXP_BITS; j++) begin : g_sqmul
      logic [2*W-1:0] mul;
      logic [2*W-1:0] sq;
      assign mul = acc_ff[j] * pbase_ff[j];
      assign sq  = pbase_ff[j] * pbase_ff[j];

      always_ff @(posedge clock) begin
         acc_ff[j+1]   <= ebits_ff[j][j] ? mul[W-1:0] : acc_ff[j];
         pbase_ff[j+1] <= sq[W-1:0];
         ebits_ff[j+1] <= ebits_ff[j];
         spec_ff[j+1]  <= spec_ff[j];
         sres_ff[j+1]  <= sres_ff[j];
         sst_ff[j+1]   <= sst_ff[j];
      end
   end

   assign res    = spec_ff[EXP_BITS] ? sres_ff[EXP_BITS] : acc_ff[EXP_BITS];
   assign status = spec_ff[EXP_BITS] ? sst_ff[EXP_BITS] : ST_OK;

endmodule

/* src/scalar_elementwise_alu_core.sv */
// scalar alu core: signed integer ops, q16.16 weighted sum, divide and power
// depth: the bit-per-stage divider sets the pipeline depth from start to the result strobe,
//   and every other op is delayed to match
// throughput: one transaction per cycle, busy stays low and the receiver cannot stall
// reset: synchronous, clears the pipeline valid bits and loads register defaults
module scalar_elementwise_alu_core
   import sea_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_first_operand,
   input  logic signed [DATA_WIDTH-1:0] req_second_operand,
   input  logic                         req_second_present,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_result,
   output logic [STATUS_WIDTH-1:0]      rsp_status,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [(DATA_WIDTH > WEIGHT_WIDTH ? DATA_WIDTH : WEIGHT_WIDTH)-1:0] csr_wdata
);

   localparam int W  = DATA_WIDTH;
   localparam int WW = WEIGHT_WIDTH;
   localparam int D  = W + 1;
   localparam int P  = $clog2(W) + 2;
   localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

   function automatic logic [W-1:0] clamp_val(input logic [W:0] x);
      if (x[W] != x[W-1]) return x[W] ? MIN_VAL : MAX_VAL;
      return x[W-1:0];
   endfunction

   function automatic status_type clamp_st(input logic [W:0] x);
      return (x[W] != x[W-1]) ? ST_SATURATED : ST_OK;
   endfunction

   // configuration registers
   op_type                   op_ff;
   logic                     won_ff;
   logic signed [WW-1:0]     wfirst_ff;
   logic signed [WW-1:0]     wsecond_ff;
   logic signed [W-1:0]      scalar_ff;
   logic                     sfirst_ff;

   // input stage
   logic [D:0]               vld_ff;
   logic signed [W-1:0]      a0_ff;
   logic signed [W-1:0]      b0_ff;

   // first level
   logic [W:0]               sum1;
   logic [W:0]               diff1;
   logic [W:0]               neg1;
   logic [W:0]               abs1;
   logic [W:0]               dba1;
   logic [W-1:0]             fast_res_in;
   status_type               fast_st_in;
   logic signed [WW-1:0]     wa;
   logic signed [WW-1:0]     wb;
   logic signed [W+WW-1:0]   wp0_in;
   logic signed [W+WW-1:0]   wp1_in;
   logic signed [2*W-1:0]    prod_in;
   logic [W:0]               sqd_in;

   logic [W-1:0]             fast_res_ff;
   status_type               fast_st_ff;
   logic signed [W+WW-1:0]   wp0_ff;
   logic signed [W+WW-1:0]   wp1_ff;
   logic signed [2*W-1:0]    prod_ff;
   logic [W:0]               sqd_ff;

   // second level
   logic signed [W+WW:0]     wsum_s;
   logic [W+WW:0]            wmag_c;
   logic [W+WW:0]            wmag_in;
   logic                     prod_ok;
   logic [2*W+1:0]           sq_in;

   logic [W+WW:0]            wmag_ff;
   logic                     wneg_ff;
   logic [W-1:0]             prod_res_ff;
   status_type               prod_st_ff;
   logic [2*W+1:0]           sq_ff;
   logic [W-1:0]             fast2_res_ff;
   status_type               fast2_st_ff;

   // third level and alignment
   logic [W-1:0]             wsum_res;
   status_type               wsum_st;
   logic [W-1:0]             sq_res;
   status_type               sq_st;
   logic [W-1:0]             arith_res_in;
   status_type               arith_st_in;
   logic [W-1:0]             arith_res_ff [3:D];
   status_type               arith_st_ff  [3:D];

   logic signed [W-1:0]      div_num;
   logic signed [W-1:0]      div_den;
   logic signed [W-1:0]      div_res;
   status_type               div_st;
   logic signed [W-1:0]      pow_res;
   status_type               pow_st;
   logic [W-1:0]             pow_res_ff [P+1:D];
   status_type               pow_st_ff  [P+1:D];

   logic [W-1:0]             out_res_in;
   status_type               out_st_in;
   logic                     rsp_valid_ff;
   logic [W-1:0]             rsp_result_ff;
   status_type               rsp_status_ff;

   // every cycle takes a transaction; register writes never wait
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff      <= OP_SUM;
         won_ff     <= 1'b0;
         wfirst_ff  <= WEIGHT_RESET;
         wsecond_ff <= WEIGHT_RESET;
         scalar_ff  <= W'(1);
         sfirst_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_OP_SELECT:     op_ff      <= op_type'(csr_wdata[OP_WIDTH-1:0]);
            CSR_WEIGHTS_ON:    won_ff     <= csr_wdata[0];
            CSR_WEIGHT_FIRST:  wfirst_ff  <= csr_wdata[WW-1:0];
            CSR_WEIGHT_SECOND: wsecond_ff <= csr_wdata[WW-1:0];
            CSR_SCALAR_VALUE:  scalar_ff  <= csr_wdata[W-1:0];
            CSR_SCALAR_FIRST:  sfirst_ff  <= csr_wdata[0];
            default:           op_ff      <= op_ff;
         endcase
      end
   end

   // valid bits follow the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[D-1:0], start};
      end
   end

   // operand capture, scalar stands in for a missing second operand
   always_ff @(posedge clock) begin
      a0_ff <= req_first_operand;
      b0_ff <= req_second_present ? req_second_operand : scalar_ff;
   end

   // single-step ops
   assign sum1  = {a0_ff[W-1], a0_ff} + {b0_ff[W-1], b0_ff};
   assign diff1 = sfirst_ff ? {b0_ff[W-1], b0_ff} - {a0_ff[W-1], a0_ff}
                            : {a0_ff[W-1], a0_ff} - {b0_ff[W-1], b0_ff};
   assign neg1  = -{a0_ff[W-1], a0_ff};
   assign abs1  = a0_ff[W-1] ? neg1 : {a0_ff[W-1], a0_ff};
   assign dba1  = {b0_ff[W-1], b0_ff} - {a0_ff[W-1], a0_ff};

   always_comb begin
      fast_res_in = '0;
      fast_st_in  = ST_OK;
      case (op_ff)
         OP_SUM: begin
            fast_res_in = clamp_val(sum1);
            fast_st_in  = clamp_st(sum1);
         end
         OP_SUB: begin
            fast_res_in = clamp_val(diff1);
            fast_st_in  = clamp_st(diff1);
         end
         OP_MIN:   fast_res_in = (a0_ff < b0_ff) ? a0_ff : b0_ff;
         OP_MAX:   fast_res_in = (a0_ff > b0_ff) ? a0_ff : b0_ff;
         OP_EQUAL: fast_res_in = (a0_ff == b0_ff) ? W'(1) : '0;
         OP_NEG: begin
            fast_res_in = clamp_val(neg1);
            fast_st_in  = clamp_st(neg1);
         end
         OP_ABS: begin
            fast_res_in = clamp_val(abs1);
            fast_st_in  = clamp_st(abs1);
         end
         OP_PROD, OP_DIV, OP_FLOORDIV, OP_SQRDIFF, OP_POW: fast_res_in = '0;
         default:  fast_st_in = ST_UNSUPPORTED;
      endcase
   end

   // weight products, operand product, distance
   assign wa      = sfirst_ff ? wsecond_ff : wfirst_ff;
   assign wb      = sfirst_ff ? wfirst_ff : wsecond_ff;
   assign wp0_in  = a0_ff * wa;
   assign wp1_in  = b0_ff * wb;
   assign prod_in = a0_ff * b0_ff;
   assign sqd_in  = dba1[W] ? (W+1)'(-dba1) : dba1;

   always_ff @(posedge clock) begin
      fast_res_ff <= fast_res_in;
      fast_st_ff  <= fast_st_in;
      wp0_ff      <= wp0_in;
      wp1_ff      <= wp1_in;
      prod_ff     <= prod_in;
      sqd_ff      <= sqd_in;
   end

   // weighted sum magnitude truncated toward zero, product range check, square
   assign wsum_s  = wp0_ff + wp1_ff;
   assign wmag_c  = wsum_s[W+WW] ? (W+WW+1)'(-wsum_s) : wsum_s;
   assign wmag_in = wmag_c >> FRAC_BITS;
   assign prod_ok = (&prod_ff[2*W-1:W-1]) || !(|prod_ff[2*W-1:W-1]);
   assign sq_in   = sqd_ff * sqd_ff;

   always_ff @(posedge clock) begin
      wmag_ff      <= wmag_in;
      wneg_ff      <= wsum_s[W+WW];
      prod_res_ff  <= prod_ok ? prod_ff[W-1:0] : (prod_ff[2*W-1] ? MIN_VAL : MAX_VAL);
      prod_st_ff   <= prod_ok ? ST_OK : ST_SATURATED;
      sq_ff        <= sq_in;
      fast2_res_ff <= fast_res_ff;
      fast2_st_ff  <= fast_st_ff;
   end

   // weighted sum saturation
   always_comb begin
      wsum_res = wmag_ff[W-1:0];
      wsum_st  = ST_OK;
      if (!wneg_ff) begin
         if (wmag_ff > (W+WW+1)'(MAX_VAL)) begin
            wsum_res = MAX_VAL;
            wsum_st  = ST_SATURATED;
         end
      end else if (wmag_ff > (W+WW+1)'(MIN_VAL)) begin
         wsum_res = MIN_VAL;
         wsum_st  = ST_SATURATED;
      end else begin
         wsum_res = W'(-wmag_ff[W-1:0]);
      end
   end

   assign sq_res = (sq_ff > (2*W+2)'(MAX_VAL)) ? MAX_VAL : sq_ff[W-1:0];
   assign sq_st  = (sq_ff > (2*W+2)'(MAX_VAL)) ? ST_SATURATED : ST_OK;

   always_comb begin
      case (op_ff)
         OP_SUM: begin
            arith_res_in = won_ff ? wsum_res : fast2_res_ff;
            arith_st_in  = won_ff ? wsum_st : fast2_st_ff;
         end
         OP_PROD: begin
            arith_res_in = prod_res_ff;
            arith_st_in  = prod_st_ff;
         end
         OP_SQRDIFF: begin
            arith_res_in = sq_res;
            arith_st_in  = sq_st;
         end
         default: begin
            arith_res_in = fast2_res_ff;
            arith_st_in  = fast2_st_ff;
         end
      endcase
   end

   // align the short paths with the divider
   always_ff @(posedge clock) begin
      arith_res_ff[3] <= arith_res_in;
      arith_st_ff[3]  <= arith_st_in;
      pow_res_ff[P+1] <= pow_res;
      pow_st_ff[P+1]  <= pow_st;
   end

   for (genvar i = 4; i <= D; i++) begin : g_arith_dly
      always_ff @(posedge clock) begin
         arith_res_ff[i] <= arith_res_ff[i-1];
         arith_st_ff[i]  <= arith_st_ff[i-1];
      end
   end

   for (genvar i = P + 2; i <= D; i++) begin : g_pow_dly
      always_ff @(posedge clock) begin
         pow_res_ff[i] <= pow_res_ff[i-1];
         pow_st_ff[i]  <= pow_st_ff[i-1];
      end
   end

   // divider, swap puts the scalar side on top
   assign div_num = sfirst_ff ? b0_ff : a0_ff;
   assign div_den = sfirst_ff ? a0_ff : b0_ff;

   sea_div #(
      .DATA_WIDTH (W)
   ) u_div (
      .clock  (clock),
      .num    (div_num),
      .den    (div_den),
      .quo    (div_res),
      .status (div_st)
   );

   sea_pow #(
      .DATA_WIDTH (W)
   ) u_pow (
      .clock  (clock),
      .base   (a0_ff),
      .expo   (b0_ff),
      .res    (pow_res),
      .status (pow_st)
   );

   // pick the finished path
   always_comb begin
      case (op_ff)
         OP_DIV, OP_FLOORDIV: begin
            out_res_in = div_res;
            out_st_in  = div_st;
         end
         OP_POW: begin
            out_res_in = pow_res_ff[D];
            out_st_in  = pow_st_ff[D];
         end
         default: begin
            out_res_in = arith_res_ff[D];
            out_st_in  = arith_st_ff[D];
         end
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[D];
      end
   end

   always_ff @(posedge clock) begin
      rsp_result_ff <= out_res_in;
      rsp_status_ff <= out_st_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_status = rsp_status_ff;

endmodule
